>>> sv/dsh_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the dtls-srtp hello matcher
// no dependencies; imported by every module of the block
package dsh_pkg;

   localparam int OFFSET_BITS = 17;
   // wide enough for an offset plus a 16-bit length plus one
   localparam int SUM_BITS    = ((OFFSET_BITS > 17) ? OFFSET_BITS : 17) + 1;

   typedef logic [OFFSET_BITS-1:0] offset_type;
   localparam offset_type OFF_MAX = '1;

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_IPV6 = 16'h86DD;

   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = 2;

   localparam logic [2:0] CSR_STUN_PORT      = 3'd0;
   localparam logic [2:0] CSR_STUN_DATA_ATTR = 3'd1;
   localparam logic [2:0] CSR_MAX_STUN_ATTRS = 3'd2;
   localparam logic [2:0] CSR_SRTP_EXT_TYPE  = 3'd3;
   localparam logic [2:0] CSR_MAX_HELLO_EXTS = 3'd4;

   typedef enum logic [1:0] {
      ETK_OTHER,
      ETK_IPV4,
      ETK_IPV6
   } et_kind_type;

   typedef struct packed {
      logic [7:0]  pkt_byte;
      offset_type  pos;
      et_kind_type et_kind;
      logic        last_byte;
   } byte_item_type;

   typedef struct packed {
      logic [15:0] stun_port;
      logic [15:0] stun_data_attr_type;
      logic [3:0]  max_stun_attrs;
      logic [15:0] srtp_ext_type;
      logic [3:0]  max_hello_exts;
   } cfg_type;

endpackage

>>> sv/dsh_front.sv
`timescale 1ns / 1ps
// front end: takes packet bytes, tracks byte position and classifies the ethertype
// depends on dsh_pkg
module dsh_front import dsh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  logic [7:0]    pkt_byte,
   input  logic [15:0]   ethertype,
   input  logic          last_byte,
   input  logic          q_full,
   output logic          q_push,
   output byte_item_type q_item
);

   offset_type pos_ff;
   offset_type pos_in;
   logic       accept;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign q_push = accept;

   always_comb begin
      q_item.pkt_byte  = pkt_byte;
      q_item.pos       = pos_ff;
      q_item.last_byte = last_byte;
      if (ethertype == ETH_IPV4) begin
         q_item.et_kind = ETK_IPV4;
      end else if (ethertype == ETH_IPV6) begin
         q_item.et_kind = ETK_IPV6;
      end else begin
         q_item.et_kind = ETK_OTHER;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (last_byte) begin
            pos_in = '0;
         end else if (pos_ff != OFF_MAX) begin
            pos_in = pos_ff + offset_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

>>> sv/dsh_queue.sv
`timescale 1ns / 1ps
// short queue of classified bytes between front and back end
// depends on dsh_pkg
module dsh_queue import dsh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  byte_item_type item_in,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output byte_item_type head
);

   byte_item_type              mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]       wr_ff, wr_in;
   logic [QPTR_BITS-1:0]       rd_ff, rd_in;
   logic [QPTR_BITS:0]         cnt_ff, cnt_in;

   assign full  = (cnt_ff == (QPTR_BITS+1)'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> sv/dsh_back.sv
`timescale 1ns / 1ps
// back end: header parser walking ip/udp/stun/dtls fields, plus the verdict queue
// depends on dsh_pkg
module dsh_back import dsh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          q_empty,
   input  byte_item_type q_head,
   output logic          q_pop,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output logic          rsp_matched
);

   localparam logic [4:0] PH_NET   = 5'd0;
   localparam logic [4:0] PH_PROTO = 5'd1;
   localparam logic [4:0] PH_DP0   = 5'd2;
   localparam logic [4:0] PH_DP1   = 5'd3;
   localparam logic [4:0] PH_AT0   = 5'd4;
   localparam logic [4:0] PH_AT1   = 5'd5;
   localparam logic [4:0] PH_AL0   = 5'd6;
   localparam logic [4:0] PH_AL1   = 5'd7;
   localparam logic [4:0] PH_RT    = 5'd8;
   localparam logic [4:0] PH_RV0   = 5'd9;
   localparam logic [4:0] PH_RV1   = 5'd10;
   localparam logic [4:0] PH_MSG   = 5'd11;
   localparam logic [4:0] PH_CV0   = 5'd12;
   localparam logic [4:0] PH_CV1   = 5'd13;
   localparam logic [4:0] PH_SID   = 5'd14;
   localparam logic [4:0] PH_COOK  = 5'd15;
   localparam logic [4:0] PH_CS0   = 5'd16;
   localparam logic [4:0] PH_CS1   = 5'd17;
   localparam logic [4:0] PH_COMP  = 5'd18;
   localparam logic [4:0] PH_ET0   = 5'd19;
   localparam logic [4:0] PH_ET1   = 5'd20;
   localparam logic [4:0] PH_EL0   = 5'd21;
   localparam logic [4:0] PH_EL1   = 5'd22;

   function automatic offset_type sat_add(input offset_type a, input logic [16:0] b);
      logic [SUM_BITS-1:0] s;
      s = SUM_BITS'(a) + SUM_BITS'(b);
      if (s > SUM_BITS'(OFF_MAX)) begin
         return OFF_MAX;
      end
      return s[OFFSET_BITS-1:0];
   endfunction

   logic [4:0] phase_ff, phase_in, ph_cur;
   offset_type target_ff, target_in, tgt_cur;
   logic [7:0] accum_ff, accum_in;
   logic [3:0] count_ff, count_in, cnt_inc;
   logic [5:0] iplen_ff, iplen_in, iplen_cur;
   logic       match_ff, match_in;
   logic       decided_ff, decided_in;

   logic       res_ff [2];
   logic       res_wr_ff, res_rd_ff;
   logic [1:0] res_cnt_ff, res_cnt_in;
   logic       res_full, res_push, res_pop, verdict;

   offset_type  p;
   logic [7:0]  b;
   logic [15:0] v;
   logic        consume;

   assign res_full    = (res_cnt_ff == 2'd2);
   assign consume     = !q_empty && !(q_head.last_byte && res_full);
   assign q_pop       = consume;
   assign res_push    = consume && q_head.last_byte;
   assign rsp_empty   = (res_cnt_ff == 2'd0);
   assign rsp_matched = res_ff[res_rd_ff];
   assign res_pop     = rsp_pop && !rsp_empty;

   assign p       = q_head.pos;
   assign b       = q_head.pkt_byte;
   assign v       = {accum_ff, b};
   assign cnt_inc = count_ff + 4'd1;

   always_comb begin
      ph_cur     = phase_ff;
      tgt_cur    = target_ff;
      iplen_cur  = iplen_ff;
      match_in   = match_ff;
      decided_in = decided_ff;
      accum_in   = accum_ff;
      count_in   = count_ff;

      // network header selection on the first byte
      if (p == '0) begin
         case (q_head.et_kind)
            ETK_IPV4: begin
               iplen_cur = 6'd20;
               ph_cur    = PH_PROTO;
               tgt_cur   = offset_type'(9);
            end
            ETK_IPV6: begin
               iplen_cur = 6'd40;
               ph_cur    = PH_PROTO;
               tgt_cur   = offset_type'(6);
            end
            default: begin
               match_in   = 1'b0;
               decided_in = 1'b1;
            end
         endcase
      end

      phase_in  = ph_cur;
      target_in = tgt_cur;
      iplen_in  = iplen_cur;

      if (!decided_in && p == tgt_cur && p != OFF_MAX) begin
         unique case (ph_cur)
            PH_PROTO: begin
               if (b != 8'd17) begin
                  match_in = 1'b0; decided_in = 1'b1;
               end else begin
                  phase_in  = PH_DP0;
                  target_in = sat_add(offset_type'(iplen_cur), 17'd2);
               end
            end
            PH_DP0: begin
               accum_in = b; phase_in = PH_DP1; target_in = sat_add(p, 17'd1);
            end
            PH_DP1: begin
               if (v == cfg.stun_port) begin
                  count_in  = 4'd0;
                  phase_in  = PH_AT0;
                  target_in = sat_add(p, 17'd25);
               end else begin
                  phase_in  = PH_RT;
                  target_in = sat_add(p, 17'd5);
               end
            end
            PH_AT0: begin
               accum_in = b; phase_in = PH_AT1; target_in = sat_add(p, 17'd1);
            end
            PH_AT1: begin
               if (v == cfg.stun_data_attr_type) begin
                  phase_in = PH_RT;  target_in = sat_add(p, 17'd3);
               end else begin
                  phase_in = PH_AL0; target_in = sat_add(p, 17'd1);
               end
            end
            PH_AL0: begin
               accum_in = b; phase_in = PH_AL1; target_in = sat_add(p, 17'd1);
            end
            PH_AL1: begin
               count_in = cnt_inc;
               if (cnt_inc >= cfg.max_stun_attrs) begin
                  match_in = 1'b0; decided_in = 1'b1;
               end else begin
                  phase_in  = PH_AT0;
                  target_in = sat_add(p, 17'(v) + 17'd1);
               end
            end
            PH_RT: begin
               if (b != 8'd22) begin
                  match_in = 1'b0; decided_in = 1'b1;
               end else begin
                  phase_in = PH_RV0; target_in = sat_add(p, 17'd1);
               end
            end
            PH_RV0: begin
               if (b != 8'd254) begin
                  match_in = 1'b0; decided_in = 1'b1;
               end else begin
                  phase_in = PH_RV1; target_in = sat_add(p, 17'd1);
               end
            end
            PH_RV1: begin
               if (b != 8'd253 && b != 8'd255) begin
                  match_in = 1'b0; decided_in = 1'b1;
               end else begin
                  phase_in = PH_MSG; target_in = sat_add(p, 17'd11);
               end
            end
            PH_MSG: begin
               if (b != 8'd1) begin
                  match_in = 1'b0; decided_in = 1'b1;
               end else begin
                  phase_in = PH_CV0; target_in = sat_add(p, 17'd12);
               end
            end
            PH_CV0: begin
               if (b != 8'd254) begin
                  match_in = 1'b0; decided_in = 1'b1;
               end else begin
                  phase_in = PH_CV1; target_in = sat_add(p, 17'd1);
               end
            end
            PH_CV1: begin
               if (b != 8'd253) begin
                  match_in = 1'b0; decided_in = 1'b1;
               end else begin
                  phase_in = PH_SID; target_in = sat_add(p, 17'd33);
               end
            end
            PH_SID: begin
               phase_in = PH_COOK; target_in = sat_add(p, 17'(b) + 17'd1);
            end
            PH_COOK: begin
               phase_in = PH_CS0; target_in = sat_add(p, 17'(b) + 17'd1);
            end
            PH_CS0: begin
               accum_in = b; phase_in = PH_CS1; target_in = sat_add(p, 17'd1);
            end
            PH_CS1: begin
               phase_in = PH_COMP; target_in = sat_add(p, 17'(v) + 17'd1);
            end
            PH_COMP: begin
               // skip compression methods and the two-byte extensions length
               count_in  = 4'd0;
               phase_in  = PH_ET0;
               target_in = sat_add(p, 17'(b) + 17'd3);
            end
            PH_ET0: begin
               accum_in = b; phase_in = PH_ET1; target_in = sat_add(p, 17'd1);
            end
            PH_ET1: begin
               match_in  = (v == cfg.srtp_ext_type);
               phase_in  = PH_EL0;
               target_in = sat_add(p, 17'd1);
            end
            PH_EL0: begin
               accum_in = b; phase_in = PH_EL1; target_in = sat_add(p, 17'd1);
            end
            PH_EL1: begin
               if (match_ff) begin
                  decided_in = 1'b1;
               end else begin
                  count_in = cnt_inc;
                  if (cnt_inc >= cfg.max_hello_exts) begin
                     match_in = 1'b0; decided_in = 1'b1;
                  end else begin
                     phase_in  = PH_ET0;
                     target_in = sat_add(p, 17'(v) + 17'd1);
                  end
               end
            end
            default: begin
               match_in = 1'b0; decided_in = 1'b1;
            end
         endcase
      end

      verdict = decided_in && match_in;

      // end of packet: back to the network header phase
      if (q_head.last_byte) begin
         phase_in   = PH_NET;
         target_in  = '0;
         accum_in   = '0;
         count_in   = '0;
         iplen_in   = '0;
         match_in   = 1'b0;
         decided_in = 1'b0;
      end
   end

   always_comb begin
      res_cnt_in = res_cnt_ff;
      if (res_push && !res_pop) begin
         res_cnt_in = res_cnt_ff + 2'd1;
      end else if (res_pop && !res_push) begin
         res_cnt_in = res_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_ff[res_wr_ff] <= verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_NET;
         target_ff  <= '0;
         accum_ff   <= '0;
         count_ff   <= '0;
         iplen_ff   <= '0;
         match_ff   <= 1'b0;
         decided_ff <= 1'b0;
         res_wr_ff  <= 1'b0;
         res_rd_ff  <= 1'b0;
         res_cnt_ff <= '0;
      end else begin
         if (consume) begin
            phase_ff   <= phase_in;
            target_ff  <= target_in;
            accum_ff   <= accum_in;
            count_ff   <= count_in;
            iplen_ff   <= iplen_in;
            match_ff   <= match_in;
            decided_ff <= decided_in;
         end
         if (res_push) begin
            res_wr_ff <= ~res_wr_ff;
         end
         if (res_pop) begin
            res_rd_ff <= ~res_rd_ff;
         end
         res_cnt_ff <= res_cnt_in;
      end
   end

   a_res_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= 2'd2)
      else $error("verdict queue overflow");

   a_packet_restart: assert property (@(posedge clock) disable iff (reset)
      consume && q_head.last_byte |=> phase_ff == PH_NET && !decided_ff && !match_ff)
      else $error("parser not restarted after last byte");

   a_no_stall_midpacket: assert property (@(posedge clock) disable iff (reset)
      !q_empty && !q_head.last_byte |-> consume)
      else $error("parser stalled on a non-final transaction");

   a_verdict_needs_ip: assert property (@(posedge clock) disable iff (reset)
      res_push && verdict |-> iplen_ff == 6'd20 || iplen_ff == 6'd40)
      else $error("match reported without an ip header");

endmodule

>>> sv/dtls_srtp_hello_matcher.sv
`timescale 1ns / 1ps
// top level of the dtls-srtp hello matcher: csr registers, front end, byte queue, parser
// depends on dsh_pkg, dsh_front, dsh_queue, dsh_back
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  req     | req_push / req_full  | req_pkt_byte, req_ethertype, req_last_byte
//  rsp     | rsp_pop / rsp_empty  | rsp_matched (one per packet)
//  csr     | csr_valid / csr_ready| csr_index, csr_wdata
//
// one byte per cycle while the verdict queue has room; the parser retires one per cycle
// a verdict shows on the rsp side the cycle after the parser takes the last byte
// a four-entry byte queue and a two-entry verdict queue decouple the sides
// rsp stalls back up through the parser only on a packet's last byte
// reset (synchronous) empties both queues and restores the csr reset values
module dtls_srtp_hello_matcher import dsh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_pkt_byte,
   input  logic [15:0] req_ethertype,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_matched,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          q_full, q_push, q_empty, q_pop;
   byte_item_type q_item, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STUN_PORT:      cfg_in.stun_port           = csr_wdata;
            CSR_STUN_DATA_ATTR: cfg_in.stun_data_attr_type = csr_wdata;
            CSR_MAX_STUN_ATTRS: cfg_in.max_stun_attrs      = csr_wdata[3:0];
            CSR_SRTP_EXT_TYPE:  cfg_in.srtp_ext_type       = csr_wdata;
            CSR_MAX_HELLO_EXTS: cfg_in.max_hello_exts      = csr_wdata[3:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stun_port           <= 16'd3478;
         cfg_ff.stun_data_attr_type <= 16'h0013;
         cfg_ff.max_stun_attrs      <= 4'd5;
         cfg_ff.srtp_ext_type       <= 16'd14;
         cfg_ff.max_hello_exts      <= 4'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .pkt_byte  (req_pkt_byte),
      .ethertype (req_ethertype),
      .last_byte (req_last_byte),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   dsh_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .item_in (q_item),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .head    (q_head)
   );

   dsh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_matched (rsp_matched)
   );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// testbench for the dtls-srtp hello matcher: packet builder, verdict scoreboard, drivers
// depends on dsh_pkg and dtls_srtp_hello_matcher; needs nothing else
module testbench;
   import dsh_pkg::*;

   localparam int unsigned POS_TOP = OFF_MAX;

   localparam logic [7:0] PROTO_UDP       = 8'd17;
   localparam logic [7:0] PROTO_TCP       = 8'd6;
   localparam logic [7:0] CT_HANDSHAKE    = 8'd22;
   localparam logic [7:0] CT_APP_DATA     = 8'd23;
   localparam logic [7:0] DTLS_MAJOR      = 8'd254;
   localparam logic [7:0] DTLS12_MINOR    = 8'd253;
   localparam logic [7:0] DTLS10_MINOR    = 8'd255;
   localparam logic [7:0] HT_CLIENT_HELLO = 8'd1;
   localparam logic [7:0] HT_SERVER_HELLO = 8'd2;
   localparam logic [15:0] ETH_ARP        = 16'h0806;

   localparam int V4_HDR_LEN   = 20;
   localparam int V6_HDR_LEN   = 40;
   localparam int V4_PROTO_AT  = 9;
   localparam int V6_NEXT_AT   = 6;

   typedef enum logic [4:0] {
      ST_NET, ST_PROTO, ST_PORT_HI, ST_PORT_LO,
      ST_ATTR_TYPE_HI, ST_ATTR_TYPE_LO, ST_ATTR_LEN_HI, ST_ATTR_LEN_LO,
      ST_REC_TYPE, ST_REC_VER_HI, ST_REC_VER_LO, ST_MSG_TYPE,
      ST_HELLO_VER_HI, ST_HELLO_VER_LO, ST_SESSION_LEN, ST_COOKIE_LEN,
      ST_SUITES_HI, ST_SUITES_LO, ST_COMP_LEN,
      ST_EXT_TYPE_HI, ST_EXT_TYPE_LO, ST_EXT_LEN_HI, ST_EXT_LEN_LO
   } parse_state_type;

   class hello_scoreboard;
      logic [15:0] cfg_stun_port, cfg_data_attr, cfg_ext_type;
      logic [3:0]  cfg_max_attrs, cfg_max_exts;

      int unsigned     pos, target, ip_len;
      parse_state_type state;
      logic [7:0]      hi_byte;
      logic [3:0]      seen;
      bit              ext_hit, settled;

      bit verdicts[$];
      int errors, packets, hits, checked;

      function new();
         cfg_stun_port = 16'd3478;
         cfg_data_attr = 16'h0013;
         cfg_max_attrs = 4'd5;
         cfg_ext_type  = 16'd14;
         cfg_max_exts  = 4'd10;
         clear_packet();
      endfunction

      function void clear_packet();
         pos = 0;
         target = 0;
         ip_len = 0;
         state = ST_NET;
         hi_byte = '0;
         seen = '0;
         ext_hit = 0;
         settled = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            CSR_STUN_PORT:      cfg_stun_port = val;
            CSR_STUN_DATA_ATTR: cfg_data_attr = val;
            CSR_MAX_STUN_ATTRS: cfg_max_attrs = val[3:0];
            CSR_SRTP_EXT_TYPE:  cfg_ext_type  = val;
            CSR_MAX_HELLO_EXTS: cfg_max_exts  = val[3:0];
            default: ;
         endcase
      endfunction

      function int unsigned sat(int unsigned a, int unsigned b);
         return (a + b > POS_TOP) ? POS_TOP : a + b;
      endfunction

      function void advance_to(parse_state_type s, int unsigned t);
         state = s;
         target = t;
      endfunction

      function void drop();
         ext_hit = 0;
         settled = 1;
      endfunction

      function void parse(logic [7:0] b);
         int unsigned word;
         word = {hi_byte, b};
         case (state)
            ST_PROTO:
               if (b != PROTO_UDP) drop();
               else advance_to(ST_PORT_HI, sat(ip_len, 2));
            ST_PORT_HI: begin
               hi_byte = b;
               advance_to(ST_PORT_LO, sat(pos, 1));
            end
            // stun: skip rest of udp header and the 20-byte stun header
            ST_PORT_LO:
               if (word == cfg_stun_port) begin
                  seen = '0;
                  advance_to(ST_ATTR_TYPE_HI, sat(pos, 25));
               end else begin
                  advance_to(ST_REC_TYPE, sat(pos, 5));
               end
            ST_ATTR_TYPE_HI: begin
               hi_byte = b;
               advance_to(ST_ATTR_TYPE_LO, sat(pos, 1));
            end
            ST_ATTR_TYPE_LO:
               if (word == cfg_data_attr) advance_to(ST_REC_TYPE, sat(pos, 3));
               else advance_to(ST_ATTR_LEN_HI, sat(pos, 1));
            ST_ATTR_LEN_HI: begin
               hi_byte = b;
               advance_to(ST_ATTR_LEN_LO, sat(pos, 1));
            end
            ST_ATTR_LEN_LO: begin
               seen = seen + 4'd1;
               if (seen >= cfg_max_attrs) drop();
               else advance_to(ST_ATTR_TYPE_HI, sat(pos, 1 + word));
            end
            ST_REC_TYPE:
               if (b != CT_HANDSHAKE) drop();
               else advance_to(ST_REC_VER_HI, sat(pos, 1));
            ST_REC_VER_HI:
               if (b != DTLS_MAJOR) drop();
               else advance_to(ST_REC_VER_LO, sat(pos, 1));
            // epoch, sequence number and record length lie between
            ST_REC_VER_LO:
               if (b != DTLS12_MINOR && b != DTLS10_MINOR) drop();
               else advance_to(ST_MSG_TYPE, sat(pos, 11));
            ST_MSG_TYPE:
               if (b != HT_CLIENT_HELLO) drop();
               else advance_to(ST_HELLO_VER_HI, sat(pos, 12));
            ST_HELLO_VER_HI:
               if (b != DTLS_MAJOR) drop();
               else advance_to(ST_HELLO_VER_LO, sat(pos, 1));
            // 32 bytes of client random
            ST_HELLO_VER_LO:
               if (b != DTLS12_MINOR) drop();
               else advance_to(ST_SESSION_LEN, sat(pos, 33));
            ST_SESSION_LEN: advance_to(ST_COOKIE_LEN, sat(pos, 1 + b));
            ST_COOKIE_LEN:  advance_to(ST_SUITES_HI, sat(pos, 1 + b));
            ST_SUITES_HI: begin
               hi_byte = b;
               advance_to(ST_SUITES_LO, sat(pos, 1));
            end
            ST_SUITES_LO: advance_to(ST_COMP_LEN, sat(pos, 1 + word));
            // also steps over the total extensions length
            ST_COMP_LEN: begin
               seen = '0;
               advance_to(ST_EXT_TYPE_HI, sat(pos, 3 + b));
            end
            ST_EXT_TYPE_HI: begin
               hi_byte = b;
               advance_to(ST_EXT_TYPE_LO, sat(pos, 1));
            end
            ST_EXT_TYPE_LO: begin
               ext_hit = (word == cfg_ext_type);
               advance_to(ST_EXT_LEN_HI, sat(pos, 1));
            end
            ST_EXT_LEN_HI: begin
               hi_byte = b;
               advance_to(ST_EXT_LEN_LO, sat(pos, 1));
            end
            ST_EXT_LEN_LO:
               if (ext_hit) begin
                  settled = 1;
               end else begin
                  seen = seen + 4'd1;
                  if (seen >= cfg_max_exts) drop();
                  else advance_to(ST_EXT_TYPE_HI, sat(pos, 1 + word));
               end
            default: drop();
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic [15:0] et, logic last);
         if (pos == 0) begin
            if (et == ETH_IPV4) begin
               ip_len = V4_HDR_LEN;
               advance_to(ST_PROTO, V4_PROTO_AT);
            end else if (et == ETH_IPV6) begin
               ip_len = V6_HDR_LEN;
               advance_to(ST_PROTO, V6_NEXT_AT);
            end else begin
               drop();
            end
         end
         if (!settled && pos == target && pos < POS_TOP) parse(b);
         pos = sat(pos, 1);
         if (last) begin
            verdicts.push_back(settled && ext_hit);
            packets++;
            if (settled && ext_hit) hits++;
            clear_packet();
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_verdict(logic got);
         bit want;
         if (verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict %0b with no packet outstanding", got));
            return;
         end
         want = verdicts.pop_front();
         if (got !== want)
            report_mismatch($sformatf("packet %0d: matched %0b, expected %0b",
                                      checked, got, want));
         checked++;
      endtask

      task flag_leftovers();
         if (verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdicts.size()));
      endtask
   endclass

   logic        clock, reset;
   logic        req_push, req_full;
   logic [7:0]  req_pkt_byte;
   logic [15:0] req_ethertype;
   logic        req_last_byte;
   logic        rsp_empty, rsp_pop, rsp_matched;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   hello_scoreboard sb;
   bit          idle_on;
   int          bytes_sent, setups;

   // packet under construction and landmarks inside it
   logic [7:0]  pkt[$];
   logic [15:0] pkt_et;
   int          proto_at, rec_at, srtp_at;

   dtls_srtp_hello_matcher uut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_pkt_byte  (req_pkt_byte),
      .req_ethertype (req_ethertype),
      .req_last_byte (req_last_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_matched   (rsp_matched),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAIL dtls_srtp_hello_matcher");
      $finish;
   end

   // ---------------- packet building ----------------

   function automatic void add_rand(int n);
      repeat (n) pkt.push_back(8'($urandom));
   endfunction

   function automatic void add16(logic [15:0] v);
      pkt.push_back(v[15:8]);
      pkt.push_back(v[7:0]);
   endfunction

   function automatic logic [15:0] pick_other(logic [15:0] avoid);
      logic [15:0] v;
      v = 16'($urandom);
      return (v == avoid) ? ~avoid : v;
   endfunction

   function automatic int short_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 600) : $urandom_range(0, 8);
   endfunction

   function automatic void build_hello(bit v6, bit stun, int n_attrs, int n_exts,
                                       bit with_srtp, bit old_rec);
      int len;
      pkt.delete();
      srtp_at = -1;
      pkt_et = v6 ? ETH_IPV6 : ETH_IPV4;
      proto_at = v6 ? V6_NEXT_AT : V4_PROTO_AT;
      add_rand(proto_at);
      pkt.push_back(PROTO_UDP);
      add_rand((v6 ? V6_HDR_LEN : V4_HDR_LEN) - proto_at - 1);
      add_rand(2);
      add16(stun ? sb.cfg_stun_port : pick_other(sb.cfg_stun_port));
      add_rand(4);
      if (stun) begin
         add_rand(20);
         repeat (n_attrs) begin
            add16(pick_other(sb.cfg_data_attr));
            len = short_len();
            add16(len);
            add_rand(len);
         end
         add16(sb.cfg_data_attr);
         add_rand(2);
      end
      rec_at = pkt.size();
      pkt.push_back(CT_HANDSHAKE);
      pkt.push_back(DTLS_MAJOR);
      pkt.push_back(old_rec ? DTLS10_MINOR : DTLS12_MINOR);
      add_rand(10);
      pkt.push_back(HT_CLIENT_HELLO);
      add_rand(11);
      pkt.push_back(DTLS_MAJOR);
      pkt.push_back(DTLS12_MINOR);
      add_rand(32);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 255) : $urandom_range(0, 32);
      pkt.push_back(len);
      add_rand(len);
      len = $urandom_range(0, 32);
      pkt.push_back(len);
      add_rand(len);
      len = 2 * $urandom_range(1, 20);
      add16(len);
      add_rand(len);
      len = $urandom_range(1, 3);
      pkt.push_back(len);
      add_rand(len);
      add_rand(2);
      repeat (n_exts) begin
         add16(pick_other(sb.cfg_ext_type));
         len = short_len();
         add16(len);
         add_rand(len);
      end
      if (with_srtp) begin
         srtp_at = pkt.size();
         add16(sb.cfg_ext_type);
         len = $urandom_range(0, 8);
         add16(len);
         add_rand(len);
      end
   endfunction

   // ---------------- drivers ----------------

   task automatic send_byte(logic [7:0] b, logic [15:0] et, logic last);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_pkt_byte  <= b;
      req_ethertype <= et;
      req_last_byte <= last;
      do @(posedge clock); while (req_full);
      sb.note_byte(b, et, last);
      bytes_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt.size(); i++)
         send_byte(pkt[i], (i == 0) ? pkt_et : 16'($urandom), i == pkt.size() - 1);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_setup(logic [15:0] port, logic [15:0] attr, logic [3:0] n_attr,
                             logic [15:0] ext, logic [3:0] n_ext);
      write_reg(CSR_STUN_PORT, port);
      write_reg(CSR_STUN_DATA_ATTR, attr);
      write_reg(CSR_MAX_STUN_ATTRS, {12'd0, n_attr});
      write_reg(CSR_SRTP_EXT_TYPE, ext);
      write_reg(CSR_MAX_HELLO_EXTS, {12'd0, n_ext});
      setups++;
   endtask

   // stop pushing, let every verdict drain, then give the parser time to go idle
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.verdicts.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic send_spoiled(int rel, logic [7:0] val);
      build_hello($urandom_range(0, 1), 0, 0, 1, 1, 0);
      pkt[rec_at + rel] = val;
      send_packet();
   endtask

   task automatic directed_packets();
      build_hello(0, 0, 0, 0, 1, 0); send_packet();   // plain ipv4 hello
      build_hello(1, 0, 0, 3, 1, 1); send_packet();   // ipv6, older record version
      build_hello(0, 1, 2, 0, 1, 0); send_packet();   // stun, data after two attributes
      build_hello(1, 1, 5, 1, 1, 0); send_packet();   // stun attribute search exhausted
      build_hello(1, 1, 4, 1, 1, 1); send_packet();   // data in last searched attribute
      build_hello(0, 0, 0, 3, 0, 0); send_packet();   // no srtp extension
      build_hello(0, 0, 0, 9, 1, 0); send_packet();   // srtp in last searched extension
      build_hello(1, 0, 0, 10, 1, 0); send_packet();  // extension search exhausted
      build_hello(0, 0, 0, 0, 1, 0);
      pkt[proto_at] = PROTO_TCP;
      send_packet();
      build_hello(0, 0, 0, 0, 1, 0);
      pkt_et = ETH_ARP;
      send_packet();
      send_spoiled(0, CT_APP_DATA);
      send_spoiled(1, DTLS_MAJOR - 8'd1);
      send_spoiled(2, DTLS12_MINOR + 8'd1);
      send_spoiled(13, HT_SERVER_HELLO);
      send_spoiled(25, DTLS_MAJOR - 8'd1);
      send_spoiled(26, DTLS10_MINOR);                  // hello must be version 1.2
      // ends after the matching type, inside its length, and right after the length
      for (int k = 2; k <= 4; k++) begin
         build_hello(0, 0, 0, 1, 1, 0);
         while (pkt.size() > srtp_at + k) void'(pkt.pop_back());
         send_packet();
      end
      pkt.delete();
      add_rand(1);
      pkt_et = ETH_IPV4;
      send_packet();
      build_hello(1, 0, 0, 0, 1, 0);
      while (pkt.size() > 12) void'(pkt.pop_back());
      send_packet();
   endtask

   task automatic random_packet();
      int kind, cut, attr_cap, ext_cap, r;
      kind = $urandom_range(0, 99);
      attr_cap = (sb.cfg_max_attrs < 15) ? int'(sb.cfg_max_attrs) + 1 : 15;
      ext_cap = (sb.cfg_max_exts < 15) ? int'(sb.cfg_max_exts) + 1 : 15;
      build_hello($urandom_range(0, 1), $urandom_range(0, 2) == 0,
                  $urandom_range(0, attr_cap), $urandom_range(0, ext_cap),
                  $urandom_range(0, 4) != 0, $urandom_range(0, 1));
      add_rand($urandom_range(0, 4));
      if (kind >= 90) begin
         // line noise
         pkt.delete();
         add_rand($urandom_range(1, 48));
         r = $urandom_range(0, 2);
         pkt_et = (r == 0) ? ETH_IPV4 : (r == 1) ? ETH_IPV6 : 16'($urandom);
      end else if (kind >= 75) begin
         if (srtp_at >= 0 && $urandom_range(0, 1) == 1) cut = srtp_at + $urandom_range(1, 4);
         else cut = $urandom_range(1, pkt.size());
         while (pkt.size() > cut) void'(pkt.pop_back());
      end else if (kind >= 60) begin
         case ($urandom_range(0, 7))
            0: r = proto_at;
            1: r = rec_at;
            2: r = rec_at + 1;
            3: r = rec_at + 2;
            4: r = rec_at + 13;
            5: r = rec_at + 25;
            6: r = rec_at + 26;
            default: r = $urandom_range(0, pkt.size() - 1);
         endcase
         pkt[r] = 8'($urandom);
      end
      send_packet();
   endtask

   // two 64k extensions push the third extension past the offset ceiling
   task automatic saturation_packet();
      build_hello(0, 0, 0, 0, 0, 0);
      repeat (2) begin
         add16(pick_other(sb.cfg_ext_type));
         add16(16'hFFFF);
         add_rand(65535);
      end
      add16(sb.cfg_ext_type);
      add16(16'd0);
      send_packet();
   endtask

   // ---------------- result side ----------------

   initial begin : pop_side
      int hold;
      hold = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) hold--;
         else if (idle_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 18);
         rsp_pop <= (hold == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_verdict(rsp_matched);
   end

   // ---------------- main sequence ----------------

   initial begin : stimulus
      sb = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_pkt_byte = '0;
      req_ethertype = '0;
      req_last_byte = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_STUN_PORT;
      csr_wdata = '0;
      idle_on = 1'b1;
      bytes_sent = 0;
      setups = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_packets();
      settle();

      for (int ph = 1; ph <= 6; ph++) begin
         case (ph)
            1: load_setup(16'h0000, 16'h0000, 4'd0, 16'h0000, 4'd0);
            2: load_setup(16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF, 4'd15);
            3: load_setup(16'($urandom), 16'($urandom), 4'd1, 16'($urandom), 4'd1);
            default: load_setup(16'($urandom), 16'($urandom), 4'($urandom_range(0, 15)),
                                16'($urandom), 4'($urandom_range(0, 15)));
         endcase
         repeat (8) begin
            idle_on = ($urandom_range(0, 9) < 7);
            random_packet();
         end
         settle();
      end

      // closing stretch runs flat out, back on the power-up values
      idle_on = 1'b0;
      load_setup(16'd3478, 16'h0013, 4'd5, 16'd14, 4'd10);
      repeat (10) random_packet();
      saturation_packet();
      settle();
      sb.flag_leftovers();

      $display("%0d packets in %0d bytes over %0d register setups, %0d verdicts checked",
               sb.packets, bytes_sent, setups + 1, sb.checked);
      $display("%0d expected matches; covered stun, truncation, corruption, noise, saturation",
               sb.hits);
      if (sb.errors == 0) $display("PASS dtls_srtp_hello_matcher");
      else $display("FAIL dtls_srtp_hello_matcher");
      $finish;
   end

endmodule
